// File: hdl/rcp_pkg.sv
// Shared types and constants of the rectangle canvas painter.
package rcp_pkg;

   // Fixed field widths
   localparam int COORD_W  = 19;
   localparam int SUM_W    = 21;
   localparam int CHAR_W   = 8;
   localparam int PIX_W    = 8;
   localparam int DIMCFG_W = 9;
   localparam int FUNC_W   = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [DIMCFG_W-1:0] CANVAS_DIM_RESET = 9'd1;
   localparam logic [CHAR_W-1:0]   BACKGROUND_RESET = 8'd32;

   // Command queue depth
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      REG_CANVAS_WIDTH     = 2'd0,
      REG_CANVAS_HEIGHT    = 2'd1,
      REG_BACKGROUND_CHAR  = 2'd2
   } reg_index_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_DRAW  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic {
      SHAPE_OUTLINE = 1'b0,
      SHAPE_FILLED  = 1'b1
   } shape_type;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_DRAW   = 3'd1,
      OP_REJECT = 3'd2,
      OP_READ   = 3'd3,
      OP_NOP    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE  = 3'd0,
      B_SWEEP = 3'd1,
      B_READ  = 3'd2,
      B_DATA  = 3'd3,
      B_REPLY = 3'd4
   } back_state_type;

   // One classified command, as it travels from the front to the back
   typedef struct packed {
      op_type                   op;
      logic                     filled;
      logic [CHAR_W-1:0]        paint_char;
      logic [PIX_W-1:0]         col;
      logic [PIX_W-1:0]         row;
      logic signed [SUM_W-1:0]  x_lo;
      logic signed [SUM_W-1:0]  x_hi;
      logic signed [SUM_W-1:0]  x_in_lo;
      logic signed [SUM_W-1:0]  x_in_hi;
      logic signed [SUM_W-1:0]  y_lo;
      logic signed [SUM_W-1:0]  y_hi;
      logic signed [SUM_W-1:0]  y_in_lo;
      logic signed [SUM_W-1:0]  y_in_hi;
   } cmd_type;

endpackage

// File: hdl/rcp_channels_if.sv
// Request and response channel interfaces of the rectangle canvas painter.
interface rcp_req_if;
   import rcp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic                      shape_kind;
   logic signed [COORD_W-1:0] left;
   logic signed [COORD_W-1:0] top;
   logic signed [COORD_W-1:0] rect_width;
   logic signed [COORD_W-1:0] rect_height;
   logic [CHAR_W-1:0]         paint_char;
   logic [PIX_W-1:0]          pixel_col;
   logic [PIX_W-1:0]          pixel_row;

   modport source (output valid, func, shape_kind, left, top, rect_width, rect_height,
                   paint_char, pixel_col, pixel_row, input ready);
   modport sink   (input valid, func, shape_kind, left, top, rect_width, rect_height,
                   paint_char, pixel_col, pixel_row, output ready);
endinterface

interface rcp_rsp_if;
   import rcp_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [CHAR_W-1:0] pixel_value;

   modport source (output valid, status, pixel_value, input ready);
   modport sink   (input valid, status, pixel_value, output ready);
endinterface

// File: hdl/rectangle_canvas_painter.sv
// Rectangle canvas painter: a character canvas that is cleared, painted and read.
//
// Usage: request words arrive on req_ch (valid/ready). func selects clear,
// draw rectangle or read pixel; every request gives exactly one response word
// on rsp_ch, in request order, with status (1 = draw rejected because width
// or height is not positive) and pixel_value (the stored character on reads).
// Canvas size and background character are written through the csr_ APB port;
// the user must write them only while the block is idle; the block does not enforce it.
// A clear or an accepted draw sweeps every in-use pixel, one per cycle.
// Throughput is set by the single write port of the canvas store driven by the sweep.
// The front takes further requests into a two-entry command queue while the
// back is busy, and a finished response waits in an output register while
// the next command already runs.
// Reset clears control state and the registers (width 1, height 1,
// background 32); the canvas contents stay undefined until cleared or
// painted. A stalled receiver holds the response and, once queue and front
// are full, deasserts req_ch.ready.
module rectangle_canvas_painter #(
   parameter int MAX_DIM   = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   rcp_req_if.sink                       req_ch,
   rcp_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rcp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import rcp_pkg::*;

   localparam int DIM_CAP = (MAX_DIM < 511) ? MAX_DIM : 511;

   logic [DIMCFG_W-1:0] width_ff, width_in;
   logic [DIMCFG_W-1:0] height_ff, height_in;
   logic [CHAR_W-1:0]   background_ff, background_in;
   logic [DIMCFG_W-1:0] width_eff, height_eff;
   logic                csr_write;
   reg_index_type       csr_index;
   logic                push_valid, push_ready;
   cmd_type             push_cmd;
   logic                pop_valid, pop;
   cmd_type             pop_cmd;

   // Register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      background_in = background_ff;
      csr_prdata    = '0;
      unique case (csr_index)
         REG_CANVAS_WIDTH: begin
            csr_prdata = CSR_DATA_W'(width_ff);
            if (csr_write) width_in = csr_pwdata[DIMCFG_W-1:0];
         end
         REG_CANVAS_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(height_ff);
            if (csr_write) height_in = csr_pwdata[DIMCFG_W-1:0];
         end
         REG_BACKGROUND_CHAR: begin
            csr_prdata = CSR_DATA_W'(background_ff);
            if (csr_write) background_in = csr_pwdata[CHAR_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= CANVAS_DIM_RESET;
         height_ff     <= CANVAS_DIM_RESET;
         background_ff <= BACKGROUND_RESET;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         background_ff <= background_in;
      end
   end

   // Clamp the canvas size into 1..DIM_CAP (MAX_DIM, at most 511)
   always_comb begin
      width_eff  = width_ff;
      height_eff = height_ff;
      if (width_ff == '0) begin
         width_eff = DIMCFG_W'(1);
      end else if (32'(width_ff) > DIM_CAP) begin
         width_eff = DIMCFG_W'(DIM_CAP);
      end
      if (height_ff == '0) begin
         height_eff = DIMCFG_W'(1);
      end else if (32'(height_ff) > DIM_CAP) begin
         height_eff = DIMCFG_W'(DIM_CAP);
      end
   end

   rcp_front #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   rcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   rcp_back #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (pop_valid),
      .cmd_pop         (pop),
      .cmd             (pop_cmd),
      .canvas_width    (width_eff),
      .canvas_height   (height_eff),
      .background_char (background_ff),
      .rsp             (rsp_ch)
   );

endmodule

// File: hdl/rcp_front.sv
// Front stage: takes request words, checks and pre-computes rectangle bounds.
module rcp_front #(
   parameter int MAX_DIM   = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   rcp_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output rcp_pkg::cmd_type push_cmd
);
   import rcp_pkg::*;

   logic                    cmd_valid_ff;
   logic                    cmd_valid_in;
   cmd_type                 cmd_ff;
   cmd_type                 cmd_in;
   logic                    accept;
   logic signed [SUM_W-1:0] one;
   logic signed [SUM_W-1:0] x0, y0, w, h;
   logic                    bad_size;
   logic                    read_out;

   // Take a new word whenever the holding register is free or moving on
   assign req.ready    = !cmd_valid_ff || push_ready;
   assign accept       = req.valid && req.ready;
   assign push_valid   = cmd_valid_ff;
   assign push_cmd     = cmd_ff;

   // Classify and pre-compute the edge bounds
   always_comb begin
      one      = SUM_W'(1) << FRAC_BITS;
      x0       = SUM_W'(req.left);
      y0       = SUM_W'(req.top);
      w        = SUM_W'(req.rect_width);
      h        = SUM_W'(req.rect_height);
      bad_size = (w <= 0) || (h <= 0);
      read_out = (32'(req.pixel_col) >= 32'(MAX_DIM)) ||
                 (32'(req.pixel_row) >= 32'(MAX_DIM));

      cmd_in            = '0;
      cmd_in.filled     = (req.shape_kind == SHAPE_FILLED);
      cmd_in.paint_char = req.paint_char;
      cmd_in.col        = req.pixel_col;
      cmd_in.row        = req.pixel_row;
      cmd_in.x_lo       = x0;
      cmd_in.x_hi       = x0 + w;
      cmd_in.x_in_lo    = x0 + one;
      cmd_in.x_in_hi    = x0 + w - one;
      cmd_in.y_lo       = y0;
      cmd_in.y_hi       = y0 + h;
      cmd_in.y_in_lo    = y0 + one;
      cmd_in.y_in_hi    = y0 + h - one;

      unique case (func_type'(req.func))
         FUNC_CLEAR: cmd_in.op = OP_CLEAR;
         FUNC_DRAW:  cmd_in.op = bad_size ? OP_REJECT : OP_DRAW;
         FUNC_READ:  cmd_in.op = read_out ? OP_NOP : OP_READ;
         default:    cmd_in.op = OP_NOP;
      endcase

      cmd_valid_in = accept || (cmd_valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: hdl/rcp_queue.sv
// Short command queue between the front and the back.
module rcp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rcp_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output rcp_pkg::cmd_type pop_cmd
);
   import rcp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("queue count beyond depth");

   a_empty_no_pop_data: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !do_pop)
      else $error("pop from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

// File: hdl/rcp_back.sv
// Back stage: sweeps the canvas store for clear and draw, serves reads.
module rcp_back #(
   parameter int MAX_DIM   = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_pop,
   input  rcp_pkg::cmd_type               cmd,
   input  logic [rcp_pkg::DIMCFG_W-1:0]   canvas_width,
   input  logic [rcp_pkg::DIMCFG_W-1:0]   canvas_height,
   input  logic [rcp_pkg::CHAR_W-1:0]     background_char,
   rcp_rsp_if.source                      rsp
);
   import rcp_pkg::*;

   localparam int DIM_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W   = 2 * DIM_BITS;
   localparam int LIM_W    = ((DIM_BITS > DIMCFG_W) ? DIM_BITS : DIMCFG_W) + 1;
   localparam int SCALED_W = DIM_BITS + FRAC_BITS + 1;
   localparam int CMP_W    = ((SCALED_W > SUM_W) ? SCALED_W : SUM_W) + 1;

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff;
   logic [DIM_BITS-1:0]     col_ff, col_in;
   logic [DIM_BITS-1:0]     row_ff, row_in;
   logic                    status_ff, status_in;
   logic [CHAR_W-1:0]       value_ff, value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff;
   logic [CHAR_W-1:0]       rsp_value_ff;
   logic [CHAR_W-1:0]       mem [2**ADDR_W];
   logic [CHAR_W-1:0]       rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    mem_we;
   logic [CHAR_W-1:0]       mem_wdata;
   logic                    col_last, row_last;
   logic                    load_rsp;
   logic signed [CMP_W-1:0] sx, sy;
   logic                    inx, iny, edgex, edgey;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.pixel_value = rsp_value_ff;

   // Sweep position and coverage test of the current pixel
   always_comb begin
      col_last = (LIM_W'(col_ff) + 1'b1) == LIM_W'(canvas_width);
      row_last = (LIM_W'(row_ff) + 1'b1) == LIM_W'(canvas_height);
      sx       = CMP_W'(col_ff) << FRAC_BITS;
      sy       = CMP_W'(row_ff) << FRAC_BITS;
      inx      = (sx >= CMP_W'(cmd_ff.x_lo)) && (sx <= CMP_W'(cmd_ff.x_hi));
      iny      = (sy >= CMP_W'(cmd_ff.y_lo)) && (sy <= CMP_W'(cmd_ff.y_hi));
      edgex    = (sx < CMP_W'(cmd_ff.x_in_lo)) || (sx > CMP_W'(cmd_ff.x_in_hi));
      edgey    = (sy < CMP_W'(cmd_ff.y_in_lo)) || (sy > CMP_W'(cmd_ff.y_in_hi));
      wr_addr  = {row_ff, col_ff};
      rd_addr  = {DIM_BITS'(cmd_ff.row), DIM_BITS'(cmd_ff.col)};
      load_rsp = (state_ff == B_REPLY) && (!rsp_valid_ff || rsp.ready);
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp.ready);
   end

   // Sequencer: pop, sweep or read, then hand the result to the output register
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      status_in = status_ff;
      value_in  = value_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = background_char;

      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               col_in    = '0;
               row_in    = '0;
               status_in = (cmd.op == OP_REJECT);
               value_in  = '0;
               unique case (cmd.op) inside
                  OP_CLEAR, OP_DRAW: state_in = B_SWEEP;
                  OP_READ:           state_in = B_READ;
                  default:           state_in = B_REPLY;
               endcase
            end
         end
         B_SWEEP: begin
            if (cmd_ff.op == OP_CLEAR) begin
               mem_we = 1'b1;
            end else begin
               mem_we    = inx && iny && (cmd_ff.filled || edgex || edgey);
               mem_wdata = cmd_ff.paint_char;
            end
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               if (row_last) begin
                  state_in = B_REPLY;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         B_READ: begin
            state_in = B_DATA;
         end
         B_DATA: begin
            value_in = rd_data_ff;
            state_in = B_REPLY;
         end
         B_REPLY: begin
            if (load_rsp) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff    <= col_in;
      row_ff    <= row_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= value_ff;
      end
   end

   // Canvas store: one write port for the sweep, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_write_only_sweep: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == B_SWEEP))
      else $error("store written outside a sweep");

   a_sweep_in_canvas: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SWEEP) |->
         (LIM_W'(col_ff) < LIM_W'(canvas_width)) && (LIM_W'(row_ff) < LIM_W'(canvas_height)))
      else $error("sweep left the canvas");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff != B_IDLE))
      else $error("popped command not taken up");

   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (cmd_ff.op != OP_READ)) |=> (rsp_value_ff == '0))
      else $error("non-read word carries pixel data");

endmodule

// File: tb/sv/rectangle_canvas_painter_test.sv
// Self-checking testbench of the rectangle canvas painter: shadow canvas, directed and random words.
package rcp_test_pkg;
   import rcp_pkg::*;

   localparam int     CANVAS_MAX = 256;
   localparam int     FRAC_BITS  = 8;
   localparam longint UNIT       = longint'(1) << FRAC_BITS;

   // One request word as the sender offers it
   typedef struct {
      func_type                  func;
      shape_type                 shape;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] rect_width;
      logic signed [COORD_W-1:0] rect_height;
      logic [CHAR_W-1:0]         paint_char;
      logic [PIX_W-1:0]          pixel_col;
      logic [PIX_W-1:0]          pixel_row;
   } canvas_command_type;

   // One response word
   typedef struct {
      logic              status;
      logic [CHAR_W-1:0] pixel_value;
   } canvas_reply_type;

   // Shadow copy of the canvas and its registers, with the replies still owed
   class canvas_shadow;
      logic [CHAR_W-1:0]   store [CANVAS_MAX*CANVAS_MAX];
      logic [DIMCFG_W-1:0] width_reg;
      logic [DIMCFG_W-1:0] height_reg;
      logic [CHAR_W-1:0]   background;
      canvas_reply_type    replies_due [$];
      int errors;
      int replies_checked;
      int clears;
      int draws_painted;
      int draws_refused;
      int reads;

      function new();
         width_reg  = CANVAS_DIM_RESET;
         height_reg = CANVAS_DIM_RESET;
         background = BACKGROUND_RESET;
         foreach (store[i]) store[i] = '0;
      endfunction

      // Out-of-range sizes act as the nearest legal one
      function int clamp_dim(logic [DIMCFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > CANVAS_MAX) return CANVAS_MAX;
         return int'(v);
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_CANVAS_WIDTH: begin
               width_reg = value[DIMCFG_W-1:0];
            end
            REG_CANVAS_HEIGHT: begin
               height_reg = value[DIMCFG_W-1:0];
            end
            REG_BACKGROUND_CHAR: begin
               background = value[CHAR_W-1:0];
            end
            default: ;
         endcase
      endfunction

      // Apply one accepted word to the shadow canvas and queue its reply
      function void take_command(canvas_command_type cmd);
         canvas_reply_type rp;
         int     cols, rows, px, py;
         longint x0, y0, wd, ht, sx, sy;
         bit     edge_y;
         rp.status      = 1'b0;
         rp.pixel_value = '0;
         cols = clamp_dim(width_reg);
         rows = clamp_dim(height_reg);
         case (cmd.func)
            FUNC_CLEAR: begin
               clears++;
               for (py = 0; py < rows; py++)
                  for (px = 0; px < cols; px++)
                     store[py*CANVAS_MAX + px] = background;
            end
            FUNC_DRAW: begin
               x0 = cmd.left;
               y0 = cmd.top;
               wd = cmd.rect_width;
               ht = cmd.rect_height;
               if (wd <= 0 || ht <= 0) begin
                  rp.status = 1'b1;
                  draws_refused++;
               end else begin
                  draws_painted++;
                  for (py = 0; py < rows; py++) begin
                     sy = longint'(py) * UNIT;
                     if (sy >= y0 && sy <= y0 + ht) begin
                        edge_y = (sy < y0 + UNIT) || (sy > y0 + ht - UNIT);
                        for (px = 0; px < cols; px++) begin
                           sx = longint'(px) * UNIT;
                           if (sx >= x0 && sx <= x0 + wd &&
                               (cmd.shape == SHAPE_FILLED || edge_y ||
                                sx < x0 + UNIT || sx > x0 + wd - UNIT))
                              store[py*CANVAS_MAX + px] = cmd.paint_char;
                        end
                     end
                  end
               end
            end
            FUNC_READ: begin
               reads++;
               rp.pixel_value = store[int'(cmd.pixel_row)*CANVAS_MAX + int'(cmd.pixel_col)];
            end
            default: ;
         endcase
         replies_due.push_back(rp);
      endfunction

      // Compare one accepted reply with the oldest one owed
      function void check_reply(logic status, logic [CHAR_W-1:0] value);
         canvas_reply_type due;
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: reply status=%0d value=%0d with nothing outstanding",
                     $time, status, value);
            return;
         end
         due = replies_due.pop_front();
         replies_checked++;
         if (status !== due.status) begin
            errors++;
            $display("%0t: wrong status, expected %0d, actual %0d", $time, due.status, status);
         end
         if (value !== due.pixel_value) begin
            errors++;
            $display("%0t: wrong pixel_value, expected %0d, actual %0d",
                     $time, due.pixel_value, value);
         end
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass
endpackage

module rectangle_canvas_painter_test;
   import rcp_pkg::*;
   import rcp_test_pkg::*;

   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rcp_req_if req_ch();
   rcp_rsp_if rsp_ch();

   canvas_shadow sb = new();

   bit quiet        = 1'b0;
   bit hold_replies = 1'b0;
   int gap_odds     = 5;
   int settings;

   rectangle_canvas_painter #(
      .MAX_DIM   (CANVAS_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Check every reply word taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_reply(rsp_ch.status, rsp_ch.pixel_value);
   end

   // Receiver: random stall bursts, one long hold on request
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_replies) begin
            hold_replies = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (n = 0; n < LONG_HOLD; n++) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, gap_odds) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("%0t: run limit reached, %0d replies outstanding", $time, sb.pending());
      $display("rectangle_canvas_painter: mismatch");
      $finish;
   end

   function automatic canvas_command_type command(func_type f, shape_type s, int left, int top,
                                                  int wd, int ht, int ch, int col, int row);
      canvas_command_type cmd;
      cmd.func        = f;
      cmd.shape       = s;
      cmd.left        = COORD_W'(left);
      cmd.top         = COORD_W'(top);
      cmd.rect_width  = COORD_W'(wd);
      cmd.rect_height = COORD_W'(ht);
      cmd.paint_char  = CHAR_W'(ch);
      cmd.pixel_col   = PIX_W'(col);
      cmd.pixel_row   = PIX_W'(row);
      return cmd;
   endfunction

   // Mostly rectangles near the canvas, some refused sizes, some full-range noise.
   // Every entry is defined by the full-canvas clear before any random word.
   function automatic canvas_command_type random_command();
      canvas_command_type cmd;
      int cols, rows, pick;
      cols = sb.clamp_dim(sb.width_reg);
      rows = sb.clamp_dim(sb.height_reg);
      pick = $urandom_range(0, 99);
      if (pick < 45)
         cmd.func = FUNC_DRAW;
      else if (pick < 80)
         cmd.func = FUNC_READ;
      else if (pick < 90)
         cmd.func = FUNC_CLEAR;
      else
         cmd.func = FUNC_NONE;
      cmd.shape       = shape_type'($urandom_range(0, 1));
      cmd.left        = COORD_W'($urandom);
      cmd.top         = COORD_W'($urandom);
      cmd.rect_width  = COORD_W'($urandom);
      cmd.rect_height = COORD_W'($urandom);
      cmd.paint_char  = CHAR_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         cmd.left        = COORD_W'(int'($urandom_range(0, (cols + 4) * 256)) - 768);
         cmd.top         = COORD_W'(int'($urandom_range(0, (rows + 4) * 256)) - 768);
         cmd.rect_width  = COORD_W'($urandom_range(1, (cols + 3) * 256));
         cmd.rect_height = COORD_W'($urandom_range(1, (rows + 3) * 256));
         // grid-aligned corners and sizes land exactly on the edge tests
         if ($urandom_range(0, 1) == 1) begin
            cmd.left[7:0]   = '0;
            cmd.top[7:0]    = '0;
            cmd.rect_width  = COORD_W'($urandom_range(1, cols + 3) * 256);
            cmd.rect_height = COORD_W'($urandom_range(1, rows + 3) * 256);
         end
      end else if (pick < 9) begin
         if ($urandom_range(0, 1) == 1)
            cmd.rect_width = COORD_W'(-int'($urandom_range(0, 262144)));
         else
            cmd.rect_height = COORD_W'(-int'($urandom_range(0, 262144)));
      end
      if ($urandom_range(0, 4) < 3) begin
         cmd.pixel_col = PIX_W'($urandom_range(0, cols - 1));
         cmd.pixel_row = PIX_W'($urandom_range(0, rows - 1));
      end else begin
         cmd.pixel_col = PIX_W'($urandom);
         cmd.pixel_row = PIX_W'($urandom);
      end
      return cmd;
   endfunction

   // Offer one word, with an occasional gap first, and hold it until taken
   task automatic offer(input canvas_command_type cmd);
      if (!quiet && $urandom_range(0, gap_odds) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= cmd.func;
      req_ch.shape_kind  <= cmd.shape;
      req_ch.left        <= cmd.left;
      req_ch.top         <= cmd.top;
      req_ch.rect_width  <= cmd.rect_width;
      req_ch.rect_height <= cmd.rect_height;
      req_ch.paint_char  <= cmd.paint_char;
      req_ch.pixel_col   <= cmd.pixel_col;
      req_ch.pixel_row   <= cmd.pixel_row;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.take_command(cmd);
   endtask

   // Drop valid and wait for every reply owed
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Setup and access cycle; the bus stays selected for a following write
   task automatic write_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.set_register(idx, value);
   endtask

   task automatic setup_canvas(input int cols, input int rows, input int bg);
      repeat (8) @(posedge clock);
      write_register(REG_CANVAS_WIDTH, cols);
      write_register(REG_CANVAS_HEIGHT, rows);
      write_register(REG_BACKGROUND_CHAR, bg);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings++;
   endtask

   initial begin
      int phase, k;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_CLEAR;
      req_ch.shape_kind  <= SHAPE_OUTLINE;
      req_ch.left        <= '0;
      req_ch.top         <= '0;
      req_ch.rect_width  <= '0;
      req_ch.rect_height <= '0;
      req_ch.paint_char  <= '0;
      req_ch.pixel_col   <= '0;
      req_ch.pixel_row   <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset size of one pixel: clear, paint, refuse, unused func
      offer(command(FUNC_CLEAR, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 0, 0, 256, 256, "R", 0, 0));
      offer(command(FUNC_READ, SHAPE_FILLED, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_DRAW, SHAPE_OUTLINE, -128, -128, 128, 128, "r", 0, 0));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 0, 0, 0, 256, "1", 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 0, 0, 262143, -262144, "1", 0, 0));
      offer(command(FUNC_NONE, SHAPE_FILLED, -1, -1, -1, -1, 255, 255, 255));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));

      // Largest canvas: defines every entry of the store
      drain_replies();
      setup_canvas(CANVAS_MAX, CANVAS_MAX, 255);
      offer(command(FUNC_CLEAR, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_DRAW, SHAPE_OUTLINE, 'hA80, 'h340, 'hC8C0, 'h6400, "R", 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 128*256, 200*256, 262143, 262143, 0, 0, 0));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 255, 255));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 20, 4));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 10, 50));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 255));

      // Small canvas: extreme corners, thinnest rectangles, reads beyond the size
      drain_replies();
      setup_canvas(5, 3, "1");
      offer(command(FUNC_CLEAR, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 262143, 0, 262143, 256, "r", 0, 0));
      offer(command(FUNC_DRAW, SHAPE_OUTLINE, -262144, -262144, 262143, 262143, "r", 0, 0));
      offer(command(FUNC_DRAW, SHAPE_OUTLINE, 256, 0, 'h300, 'h200, "R", 0, 0));
      offer(command(FUNC_DRAW, SHAPE_FILLED, 512, 256, 1, 1, "r", 0, 0));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 2, 1));
      offer(command(FUNC_READ, SHAPE_OUTLINE, 0, 0, 0, 0, 0, 200, 20));

      // Random words over several canvas settings
      for (phase = 0; phase < 5; phase++) begin
         drain_replies();
         gap_odds = $urandom_range(3, 20);
         case (phase)
            0: begin
               setup_canvas(6, 4, $urandom_range(0, 255));
               hold_replies = 1'b1;
               gap_odds     = 20;
            end
            1: begin
               setup_canvas(0, 300, 0);
            end
            2: begin
               setup_canvas(511, 1, $urandom_range(0, 255));
            end
            3: begin
               setup_canvas($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 255));
            end
            default: begin
               setup_canvas($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 255));
               quiet = 1'b1;
            end
         endcase
         for (k = 0; k < 15; k++) begin
            // sender waits for the pipeline to empty once mid-phase
            if (phase == 3 && k == 10)
               drain_replies();
            offer(random_command());
         end
      end

      drain_replies();
      repeat (300) @(posedge clock);
      $display("Checked %0d replies over %0d canvas settings, from one pixel to 256 by 256.",
               sb.replies_checked, settings);
      $display("Words: %0d clears, %0d draws painted, %0d draws refused, %0d reads.",
               sb.clears, sb.draws_painted, sb.draws_refused, sb.reads);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("rectangle_canvas_painter: match");
      else
         $display("rectangle_canvas_painter: mismatch");
      $finish;
   end
endmodule
